// ===== src/ulf_pkg.sv =====
// Shared types and constants of the UTF-8 safe line folder.
// Used by the front, the command queue and the back; no dependencies.
`timescale 1ns / 1ps

package ulf_pkg;

    // Octet classes and fold octets.
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] OCT_CR    = 8'h0D;
    localparam logic [7:0] OCT_LF    = 8'h0A;
    localparam logic [7:0] OCT_SP    = 8'h20;

    localparam int WORD_OCTETS = 8;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    // One classified input word: which emission steps the back runs, in order.
    typedef struct packed {
        logic [7:0] data;
        logic       flush_pre;
        logic       fold;
        logic       pop_one;
        logic       emit_b;
        logic       push_b;
        logic       flush_post;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_beat_t;

endpackage

// ===== src/ulf_in_if.sv =====
// Input channel of the line folder: one octet and a line-end mark per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface ulf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== src/ulf_out_if.sv =====
// Output channel of the line folder: up to eight packed octets per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface ulf_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  out_count;
    logic        out_run_end;
    logic        out_line_end;

    modport source (output valid, output out_bytes, output out_count,
                    output out_run_end, output out_line_end, input ready);
    modport sink   (input valid, input out_bytes, input out_count,
                    input out_run_end, input out_line_end, output ready);
endinterface

// ===== src/ulf_front.sv =====
// Front of the line folder: accepts octets, tracks segment state and
// classifies each octet into a command. Depends on ulf_pkg and ulf_in_if.
`timescale 1ns / 1ps

module ulf_front
    import ulf_pkg::*;
#(
    parameter int LINE_BYTES = 73
)
(
    input  logic        clk,
    input  logic        rst_n,
    ulf_in_if.sink      in_ch,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    localparam int DEPTH = LINE_BYTES - 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(LINE_BYTES + 1);

    logic [SW-1:0] seg_len_reg, seg_len_next;
    logic [CW-1:0] held_cnt_reg, held_cnt_next;
    logic          is_cont;
    logic          seg_full;

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

    assign is_cont  = (in_ch.in_byte & CONT_MASK) == CONT_TAG;
    assign seg_full = seg_len_reg >= SW'(LINE_BYTES);

    always_comb
    begin
        q_cmd         = '0;
        q_cmd.data    = in_ch.in_byte;
        seg_len_next  = seg_len_reg;
        held_cnt_next = held_cnt_reg;

        if (seg_full)
        begin
            q_cmd.fold = 1'b1;
            if (!is_cont)
            begin
                q_cmd.flush_pre = 1'b1;
                q_cmd.emit_b    = 1'b1;
                seg_len_next    = SW'(1);
                held_cnt_next   = '0;
            end
            else if (held_cnt_reg != '0)
            begin
                // The held run moves to the new segment; its first octet opens it.
                q_cmd.pop_one = 1'b1;
                q_cmd.push_b  = 1'b1;
                seg_len_next  = SW'(held_cnt_reg) + SW'(1);
            end
            else
            begin
                q_cmd.emit_b = 1'b1;
                seg_len_next = SW'(1);
            end
        end
        else if (seg_len_reg == '0)
        begin
            q_cmd.emit_b = 1'b1;
            seg_len_next = SW'(1);
        end
        else
        begin
            q_cmd.flush_pre = !is_cont;
            q_cmd.push_b    = 1'b1;
            seg_len_next    = seg_len_reg + SW'(1);
            held_cnt_next   = (is_cont ? held_cnt_reg : CW'(0)) + CW'(1);
        end

        if (in_ch.in_last)
        begin
            q_cmd.flush_post = 1'b1;
            seg_len_next     = '0;
            held_cnt_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_len_reg  <= '0;
            held_cnt_reg <= '0;
        end
        else if (q_push)
        begin
            seg_len_reg  <= seg_len_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

endmodule

// ===== src/ulf_cmd_queue.sv =====
// Short command queue between the front and the back of the line folder.
// Depends on ulf_pkg.
`timescale 1ns / 1ps

module ulf_cmd_queue
    import ulf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    output logic      full,
    output cmd_beat_t head,
    input  logic      pop
);

    cmd_t           entries [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full       = count_reg == QCW'(QUEUE_DEPTH);
    assign do_push    = push && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = count_reg != '0;
    assign head.cmd   = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCW'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - QCW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPW'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/ulf_back.sv =====
// Back of the line folder: runs each command, keeps the held-octet memory
// and packs emitted octets into output words. Depends on ulf_pkg, ulf_out_if.
`timescale 1ns / 1ps

module ulf_back
    import ulf_pkg::*;
#(
    parameter int LINE_BYTES = 73
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_beat_t head,
    output logic      pop,
    ulf_out_if.source out_ch
);

    localparam int DEPTH = LINE_BYTES - 1;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PRE_RD  = 4'd1;
    localparam logic [3:0] S_PRE_EM  = 4'd2;
    localparam logic [3:0] S_CR      = 4'd3;
    localparam logic [3:0] S_LF      = 4'd4;
    localparam logic [3:0] S_SP      = 4'd5;
    localparam logic [3:0] S_POP_RD  = 4'd6;
    localparam logic [3:0] S_POP_EM  = 4'd7;
    localparam logic [3:0] S_EMB     = 4'd8;
    localparam logic [3:0] S_PUSH    = 4'd9;
    localparam logic [3:0] S_POST_RD = 4'd10;
    localparam logic [3:0] S_POST_EM = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [7:0]    held_mem [DEPTH];
    logic [7:0]    rdata_reg;

    logic [3:0]    state_reg, state_next;
    cmd_t          cur_reg, cur_next;
    logic [CW-1:0] held_cnt_reg, held_cnt_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [63:0]   acc_reg, acc_next;
    logic [3:0]    acc_cnt_reg, acc_cnt_next;

    logic          out_valid_reg, out_valid_next;
    logic [63:0]   out_bytes_reg;
    logic [3:0]    out_count_reg;
    logic          out_run_end_reg;
    logic          out_line_end_reg;

    logic          byte_vld;
    logic [7:0]    byte_val;
    logic          need_out;
    logic          slot_free;
    logic          adv;
    logic          rd_state;

    // First step of the command at or after the given stage that has work to do.
    function automatic logic [3:0] seek(input logic [2:0] level, input cmd_t c,
                                        input logic [CW-1:0] cnt);
        logic [3:0] s;
        s = S_DONE;
        if (level <= 3'd5 && c.flush_post && cnt != '0)
            s = S_POST_RD;
        if (level <= 3'd4 && c.push_b)
            s = S_PUSH;
        if (level <= 3'd3 && c.emit_b)
            s = S_EMB;
        if (level <= 3'd2 && c.pop_one)
            s = S_POP_RD;
        if (level <= 3'd1 && c.fold)
            s = S_CR;
        if (level == 3'd0 && c.flush_pre && cnt != '0)
            s = S_PRE_RD;
        return s;
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign rd_state  = (state_reg == S_PRE_RD) || (state_reg == S_POP_RD)
                    || (state_reg == S_POST_RD);
    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        byte_vld = 1'b0;
        byte_val = rdata_reg;
        unique case (state_reg)
            S_PRE_EM, S_POP_EM, S_POST_EM:
                byte_vld = 1'b1;
            S_CR:
            begin
                byte_vld = 1'b1;
                byte_val = OCT_CR;
            end
            S_LF:
            begin
                byte_vld = 1'b1;
                byte_val = OCT_LF;
            end
            S_SP:
            begin
                byte_vld = 1'b1;
                byte_val = OCT_SP;
            end
            S_EMB:
            begin
                byte_vld = 1'b1;
                byte_val = cur_reg.data;
            end
            default:
                byte_vld = 1'b0;
        endcase
    end

    // A full accumulator goes out before the next octet enters it.
    assign need_out = (byte_vld && acc_cnt_reg == 4'(WORD_OCTETS))
                   || (state_reg == S_DONE && acc_cnt_reg != '0);
    assign adv      = !need_out || slot_free;

    always_comb
    begin
        acc_next     = acc_reg;
        acc_cnt_next = acc_cnt_reg;
        if (adv && byte_vld)
        begin
            if (acc_cnt_reg == 4'(WORD_OCTETS) || acc_cnt_reg == '0)
            begin
                acc_next     = {56'b0, byte_val};
                acc_cnt_next = 4'd1;
            end
            else
            begin
                acc_next[8*acc_cnt_reg[2:0] +: 8] = byte_val;
                acc_cnt_next = acc_cnt_reg + 4'd1;
            end
        end
        else if (adv && state_reg == S_DONE)
            acc_cnt_next = '0;
    end

    always_comb
    begin
        if (need_out && slot_free)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        held_cnt_next = held_cnt_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        pop           = 1'b0;

        if (adv)
        begin
            if (state_reg == S_PRE_EM || state_reg == S_POP_EM || state_reg == S_POST_EM)
            begin
                rd_ptr_next   = ptr_inc(rd_ptr_reg);
                held_cnt_next = held_cnt_reg - CW'(1);
            end
            if (state_reg == S_PUSH)
            begin
                wr_ptr_next   = ptr_inc(wr_ptr_reg);
                held_cnt_next = held_cnt_reg + CW'(1);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        pop        = 1'b1;
                        cur_next   = head.cmd;
                        state_next = seek(3'd0, head.cmd, held_cnt_reg);
                    end
                end
                S_PRE_RD:  state_next = S_PRE_EM;
                S_PRE_EM:  state_next = (held_cnt_next != '0) ? S_PRE_RD
                                      : seek(3'd1, cur_reg, held_cnt_next);
                S_CR:      state_next = S_LF;
                S_LF:      state_next = S_SP;
                S_SP:      state_next = seek(3'd2, cur_reg, held_cnt_next);
                S_POP_RD:  state_next = S_POP_EM;
                S_POP_EM:  state_next = seek(3'd3, cur_reg, held_cnt_next);
                S_EMB:     state_next = seek(3'd4, cur_reg, held_cnt_next);
                S_PUSH:    state_next = seek(3'd5, cur_reg, held_cnt_next);
                S_POST_RD: state_next = S_POST_EM;
                S_POST_EM: state_next = (held_cnt_next != '0) ? S_POST_RD : S_DONE;
                S_DONE:    state_next = S_IDLE;
                default:   state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PUSH)
            held_mem[wr_ptr_reg] <= cur_reg.data;
        if (rd_state)
            rdata_reg <= held_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        acc_reg <= acc_next;
        if (need_out && slot_free)
        begin
            out_bytes_reg    <= acc_reg;
            out_count_reg    <= acc_cnt_reg;
            out_run_end_reg  <= state_reg == S_DONE;
            out_line_end_reg <= (state_reg == S_DONE) && cur_reg.flush_post;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_cnt_reg  <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_cnt_reg  <= held_cnt_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            acc_cnt_reg   <= acc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_bytes    = out_bytes_reg;
    assign out_ch.out_count    = out_count_reg;
    assign out_ch.out_run_end  = out_run_end_reg;
    assign out_ch.out_line_end = out_line_end_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg != '0 && out_count_reg <= 4'(WORD_OCTETS)))
        else $error("output word with an octet count out of range");

    a_line_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_line_end_reg) |-> out_run_end_reg)
        else $error("line end on a word that does not close its run");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg <= CW'(DEPTH))
        else $error("held octet count beyond the memory depth");

    a_idle_acc_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (acc_cnt_reg == '0))
        else $error("octets left in the packer between commands");

endmodule

// ===== src/utf8_safe_line_folder.sv =====
// An octet is queued at the accepting edge; the back pops it from the queue when idle,
// runs its steps one at a time and registers each packed word; a held run may be flushed
// first. A fold emits CR, LF and SP; each octet from the held-octet memory is read and then
// emitted. The back finishes one command before it takes the next; a busy output holds it.
// Reset (rst_n, asynchronous) clears all control state; the held-octet memory has no
// reset, needs no clearing pass and is only read where written.
`timescale 1ns / 1ps

module utf8_safe_line_folder
    import ulf_pkg::*;
#(
    parameter int LINE_BYTES = 73
)
(
    input  logic      clk,
    input  logic      rst_n,
    ulf_in_if.sink    in_ch,
    ulf_out_if.source out_ch
);

    logic      q_full;
    logic      q_push;
    cmd_t      q_cmd;
    cmd_beat_t q_head;
    logic      q_pop;

    ulf_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_cmd)
    );

    ulf_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .head     (q_head),
        .pop      (q_pop)
    );

    ulf_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .pop    (q_pop),
        .out_ch (out_ch)
    );

endmodule
